[rtl/core/mcs_pkg.sv]
// Shared constants and types of the MIDI chunk header scanner.
package mcs_pkg;

  localparam int unsigned WIN_LEN = 14;
  localparam int unsigned HDR_LEN = 14;
  localparam int unsigned TRK_LEN = 8;
  localparam int unsigned FILL_W  = $clog2(WIN_LEN + 1);

  localparam logic [7:0] CHR_M = 8'h4D;
  localparam logic [7:0] CHR_T = 8'h54;
  localparam logic [7:0] CHR_H = 8'h68;
  localparam logic [7:0] CHR_D = 8'h64;
  localparam logic [7:0] CHR_R = 8'h72;
  localparam logic [7:0] CHR_K = 8'h6B;

  localparam logic [31:0] HDR_MIN_SIZE = 32'd6;
  localparam logic [15:0] FMT_MAX      = 16'd2;

  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_TRK = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // Configuration port
  localparam int unsigned CFG_AW          = 3;
  localparam logic        REG_MAX_TRK_LEN = 1'b0;

  typedef logic [WIN_LEN-1:0][7:0] win_t;

  typedef struct packed {
    logic        hdr_ok;
    logic        trk_ok;
    logic [1:0]  format;
    logic [15:0] track_count;
    logic [15:0] division;
    logic [30:0] extra_header_bytes;
    logic [30:0] track_size;
  } match_t;

endpackage

[rtl/core/mcs_in_if.sv]
// Input channel: one file byte per item with its end-of-buffer flag.
interface mcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

[rtl/core/mcs_out_if.sv]
// Result channel: one chunk or end-of-buffer report per item.
interface mcs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] skipped;
  logic [1:0]  format;
  logic [15:0] track_count;
  logic [15:0] division;
  logic [30:0] extra_header_bytes;
  logic [30:0] track_size;
  logic        last_of_run;

  modport source (output valid, output kind, output skipped, output format,
                  output track_count, output division, output extra_header_bytes,
                  output track_size, output last_of_run, input ready);
  modport sink (input valid, input kind, input skipped, input format,
                input track_count, input division, input extra_header_bytes,
                input track_size, input last_of_run, output ready);
endinterface

[rtl/core/mcs_cell.sv]
// One byte cell of the scan window: loads the incoming byte or takes its neighbour's.
module mcs_cell
  import mcs_pkg::*;
(
  input  logic              clk,
  input  logic              shift_en,
  input  logic              load_en,
  input  logic [FILL_W-1:0] cell_idx,
  input  logic [FILL_W-1:0] fill,
  input  logic [7:0]        in_byte,
  input  logic [7:0]        nbr_byte,
  output logic [7:0]        byte_q
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (shift_en) begin
      byte_nxt = nbr_byte;
    end else if (load_en && (fill == cell_idx)) begin
      byte_nxt = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;

endmodule

[rtl/core/mcs_match.sv]
// Header and track tests on the position at the head of the window.
module mcs_match
  import mcs_pkg::*;
(
  input  win_t              win,
  input  logic [FILL_W-1:0] fill,
  input  logic [30:0]       max_track_len,
  output match_t            m
);

  logic [31:0] size;
  logic [15:0] fmt;
  logic [15:0] div;
  logic        is_mthd;
  logic        is_mtrk;
  logic        trk_fits;

  always_comb begin
    size = {win[4], win[5], win[6], win[7]};
    fmt  = {win[8], win[9]};
    div  = {win[12], win[13]};

    is_mthd = (win[0] == CHR_M) && (win[1] == CHR_T) && (win[2] == CHR_H) &&
              (win[3] == CHR_D);
    is_mtrk = (win[0] == CHR_M) && (win[1] == CHR_T) && (win[2] == CHR_R) &&
              (win[3] == CHR_K);
    // zero limit: any size goes
    trk_fits = (max_track_len == 31'd0) || (size[30:0] <= max_track_len);

    m.hdr_ok = (fill >= FILL_W'(HDR_LEN)) && is_mthd && !size[31] &&
               (size >= HDR_MIN_SIZE) && (fmt <= FMT_MAX) && (div != 16'd0);
    m.trk_ok = (fill >= FILL_W'(TRK_LEN)) && is_mtrk && !size[31] && trk_fits;
    m.format             = fmt[1:0];
    m.track_count        = {win[10], win[11]};
    m.division           = div;
    m.extra_header_bytes = size[30:0] - HDR_MIN_SIZE[30:0];
    m.track_size         = size[30:0];
  end

endmodule

[rtl/core/midi_chunk_header_scanner_top.sv]
// Top level of the MIDI chunk header scanner: window chain, sequencer, results, registers.
//
//  channel  | direction | handshake          | payload
//  in_ch    | in        | valid/ready        | data_byte, end_of_buffer
//  out_ch   | out       | valid/ready        | kind, skipped, header and track fields
//  APB      | in        | psel/penable/pready | max_track_len at byte address 0
//
// While the window fills, each byte is only accepted; with the window full, each byte
// is accepted and then one position is tested by the match unit. A track found passes
// through the discard state while the 14-cell chain shifts out the rest of its header.
// After the last byte of a buffer the drain tests each remaining position in turn and
// then sends the end report. Reset has no clearing pass. A waiting result stalls
// the tests; once the window is full, or the buffer has ended, that holds off the
// input as well.
module midi_chunk_header_scanner_top
  import mcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mcs_in_if.sink            in_ch,
  mcs_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_RESOLVE = 2'd1;
  localparam logic [1:0] ST_DRAIN   = 2'd2;
  localparam logic [1:0] ST_DISCARD = 2'd3;

  localparam int unsigned DCNT_W = $clog2(TRK_LEN);
  localparam logic [DCNT_W-1:0] DISCARD_LEN = DCNT_W'(TRK_LEN - 1);

  logic [1:0]        state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [31:0]       skip_r, skip_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              drain_r, drain_nxt;
  logic [30:0]       max_len_r, max_len_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [31:0] out_skip_r, out_skip_nxt;
  logic [1:0]  out_fmt_r, out_fmt_nxt;
  logic [15:0] out_tcnt_r, out_tcnt_nxt;
  logic [15:0] out_div_r, out_div_nxt;
  logic [30:0] out_extra_r, out_extra_nxt;
  logic [30:0] out_tsize_r, out_tsize_nxt;
  logic        out_last_r, out_last_nxt;

  logic   accept;
  logic   out_free;
  logic   shift_en;
  logic   cfg_we;
  win_t   win;
  match_t m;
  logic [31:0] skip_inc;

  // ---------------------------------------------------------------- window chain
  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    logic [7:0] nbr;
    if (i == WIN_LEN - 1) begin : g_tail
      assign nbr = 8'h00;
    end else begin : g_body
      assign nbr = win[i+1];
    end
    mcs_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .load_en  (accept),
      .cell_idx (FILL_W'(i)),
      .fill     (fill_r),
      .in_byte  (in_ch.data_byte),
      .nbr_byte (nbr),
      .byte_q   (win[i])
    );
  end

  mcs_match u_match (
    .win           (win),
    .fill          (fill_r),
    .max_track_len (max_len_r),
    .m             (m)
  );

  // ---------------------------------------------------------------- registers
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_TRK_LEN) ? {1'b0, max_len_r} : 32'd0;

  always_comb begin
    max_len_nxt = max_len_r;
    if (cfg_we && (paddr[2] == REG_MAX_TRK_LEN)) begin
      max_len_nxt = pwdata[30:0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign skip_inc    = (skip_r == 32'hFFFF_FFFF) ? skip_r : skip_r + 32'd1;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    skip_nxt  = skip_r;
    dcnt_nxt  = dcnt_r;
    drain_nxt = drain_r;
    shift_en  = 1'b0;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_skip_nxt  = out_skip_r;
    out_fmt_nxt   = out_fmt_r;
    out_tcnt_nxt  = out_tcnt_r;
    out_div_nxt   = out_div_r;
    out_extra_nxt = out_extra_r;
    out_tsize_nxt = out_tsize_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          fill_nxt = fill_r + FILL_W'(1);
          if (in_ch.end_of_buffer) begin
            state_nxt = ST_DRAIN;
          end else if (fill_r == FILL_W'(WIN_LEN - 1)) begin
            state_nxt = ST_RESOLVE;
          end
        end
      end
      ST_RESOLVE, ST_DRAIN: begin
        if (out_free) begin
          if ((state_r == ST_DRAIN) && (fill_r == '0)) begin
            // buffer exhausted: report the end and start afresh
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_END;
            out_skip_nxt  = skip_r;
            out_fmt_nxt   = 2'd0;
            out_tcnt_nxt  = 16'd0;
            out_div_nxt   = 16'd0;
            out_extra_nxt = 31'd0;
            out_tsize_nxt = 31'd0;
            out_last_nxt  = 1'b1;
            skip_nxt      = 32'd0;
            state_nxt     = ST_IDLE;
          end else if (m.hdr_ok) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_HDR;
            out_skip_nxt  = skip_r;
            out_fmt_nxt   = m.format;
            out_tcnt_nxt  = m.track_count;
            out_div_nxt   = m.division;
            out_extra_nxt = m.extra_header_bytes;
            out_tsize_nxt = 31'd0;
            out_last_nxt  = (state_r == ST_RESOLVE);
            skip_nxt      = 32'd0;
            fill_nxt      = '0;   // header fills the whole window
            if (state_r == ST_RESOLVE) begin
              state_nxt = ST_IDLE;
            end
          end else if (m.trk_ok) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_TRK;
            out_skip_nxt  = skip_r;
            out_fmt_nxt   = 2'd0;
            out_tcnt_nxt  = 16'd0;
            out_div_nxt   = 16'd0;
            out_extra_nxt = 31'd0;
            out_tsize_nxt = m.track_size;
            out_last_nxt  = (state_r == ST_RESOLVE);
            skip_nxt      = 32'd0;
            shift_en      = 1'b1;
            fill_nxt      = fill_r - FILL_W'(1);
            dcnt_nxt      = DISCARD_LEN;
            drain_nxt     = (state_r == ST_DRAIN);
            state_nxt     = ST_DISCARD;
          end else begin
            // no chunk here: drop one byte
            skip_nxt = skip_inc;
            shift_en = 1'b1;
            fill_nxt = fill_r - FILL_W'(1);
            if (state_r == ST_RESOLVE) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_DISCARD: begin
        // shift out the rest of the track header
        shift_en = 1'b1;
        fill_nxt = fill_r - FILL_W'(1);
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (dcnt_r == DCNT_W'(1)) begin
          state_nxt = drain_r ? ST_DRAIN : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      skip_r      <= 32'd0;
      dcnt_r      <= '0;
      drain_r     <= 1'b0;
      max_len_r   <= 31'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      skip_r      <= skip_nxt;
      dcnt_r      <= dcnt_nxt;
      drain_r     <= drain_nxt;
      max_len_r   <= max_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_skip_r  <= out_skip_nxt;
    out_fmt_r   <= out_fmt_nxt;
    out_tcnt_r  <= out_tcnt_nxt;
    out_div_r   <= out_div_nxt;
    out_extra_r <= out_extra_nxt;
    out_tsize_r <= out_tsize_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.kind               = out_kind_r;
  assign out_ch.skipped            = out_skip_r;
  assign out_ch.format             = out_fmt_r;
  assign out_ch.track_count        = out_tcnt_r;
  assign out_ch.division           = out_div_r;
  assign out_ch.extra_header_bytes = out_extra_r;
  assign out_ch.track_size         = out_tsize_r;
  assign out_ch.last_of_run        = out_last_r;

  // ---------------------------------------------------------------- checks
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (fill_r < FILL_W'(WIN_LEN)))
    else $error("byte accepted into a full window");

  a_resolve_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESOLVE) |-> (fill_r == FILL_W'(WIN_LEN)))
    else $error("position tested before the window is full");

  a_end_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_buffer) |=> (state_r == ST_DRAIN))
    else $error("last byte did not start the drain");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_END)) |-> out_last_r)
    else $error("end report not marked last of run");

  a_discard_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DISCARD) |-> ((dcnt_r != '0) && (fill_r != '0)))
    else $error("track discard ran past the window");

endmodule

[tb/mcs_tb_pkg.sv]
// Chunk tracker for the MIDI chunk header scanner bench: window model and result checks.
`timescale 1ns / 1ps
package mcs_tb_pkg;
  import mcs_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] skipped;
    logic [1:0]  format;
    logic [15:0] track_count;
    logic [15:0] division;
    logic [30:0] extra_header_bytes;
    logic [30:0] track_size;
    logic        last_of_run;
  } report_t;

  class chunk_tracker;
    logic [7:0]  win [WIN_LEN];
    int unsigned fill;
    logic [31:0] skip;
    logic [30:0] track_limit;
    report_t     pending [$];
    int          mismatches;

    function new();
      clear_window();
      skip        = '0;
      track_limit = '0;
      mismatches  = 0;
    endfunction

    function void clear_window();
      foreach (win[i]) win[i] = 8'h00;
      fill = 0;
    endfunction

    function logic [31:0] word32(int unsigned p);
      return {win[p], win[p + 1], win[p + 2], win[p + 3]};
    endfunction

    function logic [15:0] word16(int unsigned p);
      return {win[p], win[p + 1]};
    endfunction

    // Drop k bytes from the front of the window, never more than it holds.
    function void shift(int unsigned k);
      if (k > fill) k = fill;
      for (int i = 0; i < WIN_LEN; i++) begin
        win[i] = (i + k < WIN_LEN) ? win[i + k] : 8'h00;
      end
      fill -= k;
    endfunction

    // Test the position at the window start: header first, then track.
    function bit resolve(output report_t r);
      logic [31:0] size;
      logic [31:0] extra;
      logic [15:0] fmt;
      logic [15:0] div;
      r = '0;
      if (fill >= HDR_LEN && win[0] == CHR_M && win[1] == CHR_T &&
          win[2] == CHR_H && win[3] == CHR_D) begin
        size = word32(4);
        fmt  = word16(8);
        div  = word16(12);
        if (!size[31] && size >= HDR_MIN_SIZE && fmt <= FMT_MAX && div != 16'h0000) begin
          extra                = size - HDR_MIN_SIZE;
          r.kind               = KIND_HDR;
          r.skipped            = skip;
          r.format             = fmt[1:0];
          r.track_count        = word16(10);
          r.division           = div;
          r.extra_header_bytes = extra[30:0];
          skip = '0;
          shift(HDR_LEN);
          return 1'b1;
        end
      end
      if (fill >= TRK_LEN && win[0] == CHR_M && win[1] == CHR_T &&
          win[2] == CHR_R && win[3] == CHR_K) begin
        size = word32(4);
        if (!size[31] && (track_limit == '0 || size[30:0] <= track_limit)) begin
          r.kind       = KIND_TRK;
          r.skipped    = skip;
          r.track_size = size[30:0];
          skip = '0;
          shift(TRK_LEN);
          return 1'b1;
        end
      end
      if (skip != '1) skip++;
      shift(1);
      return 1'b0;
    endfunction

    function void note_byte(logic [7:0] data, logic eob);
      report_t r;
      report_t fresh [$];
      if (fill >= WIN_LEN) shift(1);
      win[fill] = data;
      fill++;
      if (!eob) begin
        if (fill == WIN_LEN && resolve(r)) fresh.push_back(r);
      end else begin
        // only the first chunk found can fit; the rest of the window just drains
        while (fill > 0) begin
          if (resolve(r) && fresh.size() == 0) fresh.push_back(r);
        end
        r         = '0;
        r.kind    = KIND_END;
        r.skipped = skip;
        fresh.push_back(r);
        skip = '0;
        clear_window();
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last_of_run = 1'b1;
      foreach (fresh[i]) pending.push_back(fresh[i]);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending.size() == 0) begin
        $error("result with none expected: kind %0d skipped %0d", got.kind, got.skipped);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("skipped", want.skipped, got.skipped);
      compare_field("format", want.format, got.format);
      compare_field("track_count", want.track_count, got.track_count);
      compare_field("division", want.division, got.division);
      compare_field("extra_header_bytes", want.extra_header_bytes, got.extra_header_bytes);
      compare_field("track_size", want.track_size, got.track_size);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

endpackage

[tb/tb_midi_chunk_header_scanner_top.sv]
// Bench for the MIDI chunk header scanner: chunk streams in, checked reports out, APB limit.
`timescale 1ns / 1ps
module tb_midi_chunk_header_scanner_top;
  import mcs_pkg::*;
  import mcs_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_BYTES  = 250;
  localparam int IDLE_PCT     = 23;

  typedef struct {
    logic [7:0] data;
    logic       eob;
  } plan_t;

  typedef enum {PIECE_HDR, PIECE_TRK, PIECE_BAD_HDR, PIECE_BAD_TRK, PIECE_NOISE} piece_e;
  typedef enum {
    FLAW_NONE, FLAW_SHORT_SIZE, FLAW_SIZE_TOP_BIT, FLAW_BAD_FORMAT, FLAW_ZERO_DIVISION,
    FLAW_BAD_MAGIC
  } hdr_flaw_e;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  mcs_in_if  byte_ch ();
  mcs_out_if report_ch ();

  chunk_tracker tracker = new();
  plan_t        byte_plan [$];
  bit           steady;
  bit           hold_asked;
  int           cycle_count;

  midi_chunk_header_scanner_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (byte_ch),
    .out_ch  (report_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void add_byte(logic [7:0] b);
    plan_t p;
    p.data = b;
    p.eob  = 1'b0;
    byte_plan.push_back(p);
  endfunction

  function automatic void push_be(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endfunction

  // Chunk id "MT" plus two letters; spoil flips bits of one of the four.
  function automatic void push_id(logic [7:0] c2, logic [7:0] c3, bit spoil);
    logic [7:0] id [4];
    int unsigned idx;
    id = '{CHR_M, CHR_T, c2, c3};
    if (spoil) begin
      idx     = $urandom_range(3);
      id[idx] = id[idx] ^ 8'($urandom_range(255, 1));
    end
    foreach (id[i]) add_byte(id[i]);
  endfunction

  function automatic void close_buffer();
    byte_plan[byte_plan.size() - 1].eob = 1'b1;
  endfunction

  function automatic void plan_piece(logic [30:0] limit);
    piece_e      piece;
    hdr_flaw_e   flaw;
    logic [31:0] size;
    logic [15:0] fmt;
    logic [15:0] div;
    bit          spoil;
    int unsigned pick;
    pick  = $urandom_range(9);
    piece = pick < 3 ? PIECE_HDR : pick < 6 ? PIECE_TRK : pick == 6 ? PIECE_BAD_HDR :
            pick == 7 ? PIECE_BAD_TRK : PIECE_NOISE;
    case (piece)
      PIECE_HDR, PIECE_BAD_HDR: begin
        case ($urandom_range(2))
          0: size = HDR_MIN_SIZE;
          1: size = HDR_MIN_SIZE + $urandom_range(30);
          default: size = $urandom_range(32'h7FFF_FFFF, 6);
        endcase
        fmt  = $urandom_range(FMT_MAX);
        div  = $urandom_range(16'hFFFF, 1);
        flaw = FLAW_NONE;
        if (piece == PIECE_BAD_HDR) begin
          flaw = hdr_flaw_e'($urandom_range(int'(FLAW_BAD_MAGIC), int'(FLAW_SHORT_SIZE)));
        end
        case (flaw)
          FLAW_SHORT_SIZE:    size = $urandom_range(5);
          FLAW_SIZE_TOP_BIT:  size[31] = 1'b1;
          FLAW_BAD_FORMAT:    fmt = $urandom_range(16'hFFFF, 3);
          FLAW_ZERO_DIVISION: div = 16'h0000;
          default: ;
        endcase
        push_id(CHR_H, CHR_D, flaw == FLAW_BAD_MAGIC);
        push_be(size, 4);
        push_be(fmt, 2);
        push_be($urandom, 2);
        push_be(div, 2);
      end
      PIECE_TRK, PIECE_BAD_TRK: begin
        case ($urandom_range(3))
          0: size = $urandom_range(limit);
          1: size = limit;
          2: size = {1'b0, limit} + $urandom_range(300, 1);
          default: size = $urandom & 32'h7FFF_FFFF;
        endcase
        spoil = 1'b0;
        if (piece == PIECE_BAD_TRK) begin
          if ($urandom_range(1)) size[31] = 1'b1;
          else spoil = 1'b1;
        end
        push_id(CHR_R, CHR_K, spoil);
        push_be(size, 4);
        // a short body that the scanner has to skip
        repeat ($urandom_range(4)) add_byte($urandom);
      end
      default: begin
        repeat ($urandom_range(6, 1)) add_byte($urandom_range(3) == 0 ? CHR_M : 8'($urandom));
      end
    endcase
  endfunction

  function automatic void plan_buffer(logic [30:0] limit);
    int unsigned start;
    int unsigned cut;
    start = byte_plan.size();
    repeat ($urandom_range(5, 1)) plan_piece(limit);
    // now and then cut the buffer short so a chunk runs past its end
    if ($urandom_range(5) == 0) begin
      cut = $urandom_range(6, 1);
      while (cut > 0 && byte_plan.size() > start + 1) begin
        void'(byte_plan.pop_back());
        cut--;
      end
    end
    close_buffer();
  endfunction

  task automatic feed_bytes();
    while (byte_plan.size() > 0) begin
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
        byte_ch.valid <= 1'b0;
        @(posedge clk);
      end
      byte_ch.valid         <= 1'b1;
      byte_ch.data_byte     <= byte_plan[0].data;
      byte_ch.end_of_buffer <= byte_plan[0].eob;
      do @(posedge clk); while (!byte_ch.ready);
      tracker.note_byte(byte_plan[0].data, byte_plan[0].eob);
      void'(byte_plan.pop_front());
    end
    byte_ch.valid <= 1'b0;
  endtask

  // Wait for every expected report, then let a trailing end scan run out.
  task automatic settle();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= CFG_AW'(4 * int'(REG_MAX_TRK_LEN));
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_track_limit(logic [30:0] limit);
    logic [31:0] readback;
    // the spare top bit of the write data must be ignored
    apb_access(1'b1, {1'($urandom_range(1)), limit}, readback);
    tracker.track_limit = limit;
    apb_access(1'b0, '0, readback);
    if (readback[30:0] !== limit) begin
      $error("max_track_len: expected 0x%0h, got 0x%0h", limit, readback[30:0]);
      tracker.mismatches++;
    end
  endtask

  initial begin
    report_t got;
    int      hold_left;
    hold_left = 0;
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (report_ch.valid && report_ch.ready) begin
          got.kind               = report_ch.kind;
          got.skipped            = report_ch.skipped;
          got.format             = report_ch.format;
          got.track_count        = report_ch.track_count;
          got.division           = report_ch.division;
          got.extra_header_bytes = report_ch.extra_header_bytes;
          got.track_size         = report_ch.track_size;
          got.last_of_run        = report_ch.last_of_run;
          tracker.check_report(got);
        end
        if (hold_left > 0) begin
          report_ch.ready <= 1'b0;
          hold_left--;
        end else if (hold_asked) begin
          // long hold-off: let the window back up and stall the byte stream
          hold_asked = 1'b0;
          hold_left  = LONG_HOLD;
          report_ch.ready <= 1'b0;
        end else begin
          report_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("midi_chunk_header_scanner_top test failed");
    $finish;
  end

  initial begin
    logic [30:0] limits [6];
    byte_ch.valid         <= 1'b0;
    byte_ch.data_byte     <= 8'h00;
    byte_ch.end_of_buffer <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    steady     = 1'b0;
    hold_asked = 1'b0;
    limits = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd40, 31'd0, 31'd0};
    limits[4] = $urandom_range(1000, 2);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // header with the largest format and division and the minimum size
    push_id(CHR_H, CHR_D, 1'b0);
    push_be(HDR_MIN_SIZE, 4);
    push_be(FMT_MAX, 2);
    push_be(16'hFFFF, 2);
    push_be(16'hFFFF, 2);
    close_buffer();
    // one-byte buffer: nothing but the end report
    add_byte(8'h00);
    close_buffer();
    // empty track right at the end of a buffer
    push_id(CHR_R, CHR_K, 1'b0);
    push_be(32'd0, 4);
    close_buffer();
    feed_bytes();
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      set_track_limit(limits[phase]);
      steady     = (phase == 1);
      hold_asked = (phase == 3);
      while (byte_plan.size() < PHASE_BYTES) plan_buffer(limits[phase]);
      feed_bytes();
      settle();
    end

    if (tracker.mismatches == 0) begin
      $display("midi_chunk_header_scanner_top test passed");
    end else begin
      $display("midi_chunk_header_scanner_top test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/mcs_pkg.sv
rtl/core/mcs_in_if.sv
rtl/core/mcs_out_if.sv
rtl/core/mcs_cell.sv
rtl/core/mcs_match.sv
rtl/core/midi_chunk_header_scanner_top.sv
tb/mcs_tb_pkg.sv
tb/tb_midi_chunk_header_scanner_top.sv
